// ===== rtl/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
package skt_pkg;

  localparam logic [1:0] MODE_LOOKUP  = 2'd0;
  localparam logic [1:0] MODE_INSERT  = 2'd1;
  localparam logic [1:0] MODE_SPECIAL = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [2:0] TYPE_DEFERRED = 3'd6;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  found_index;
    logic [2:0]  found_type;
    logic [31:0] found_payload;
    logic [31:0] assigned_key;
    logic        replaced_warning;
  } result_t;

endpackage

// ===== rtl/sorted_key_table.sv =====
// Top level of the sorted key table: sequencer, search and sift around one memory.
//
//  channel | ports                                            | direction
//  in      | in_valid/in_ready, in_mode, in_key, in_entry_type, in_payload | to block
//  out     | out_valid/out_ready, out_status, out_found_*, out_assigned_key,
//          | out_replaced_warning                               | from block
//
// One item at a time. A lookup runs one binary-search probe after another,
// each an address step, a registered read and a compare. An insert searches
// the same way, then sifts the new entry down past every larger key through
// the one read port and the one write port; a special insert first reads
// the largest key. Reset (rst_n low, synchronous) empties the table; the
// memory is not cleared. The result is held in an output register until
// taken; in_ready stays low meanwhile.
module sorted_key_table #(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_key,
  input  logic [2:0]  in_entry_type,
  input  logic [31:0] in_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_found_index,
  output logic [2:0]  out_found_type,
  output logic [31:0] out_found_payload,
  output logic [31:0] out_assigned_key,
  output logic        out_replaced_warning
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [KEY_BITS-1:0] KEY_ONES = '1;
  localparam logic [KEY_BITS-1:0] SPEC_FIRST = KEY_BITS'(1) << (KEY_BITS - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LASTRD = 4'd1;
  localparam logic [3:0] S_LASTWT = 4'd2;
  localparam logic [3:0] S_PROBE  = 4'd3;
  localparam logic [3:0] S_WAIT   = 4'd4;
  localparam logic [3:0] S_CMP    = 4'd5;
  localparam logic [3:0] S_SRD    = 4'd6;
  localparam logic [3:0] S_SWT    = 4'd7;
  localparam logic [3:0] S_SCMP   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       lo_r, lo_nxt, hi_r, hi_nxt, pos_r, pos_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [2:0]          type_r, type_nxt;
  logic [31:0]         pay_r, pay_nxt;
  skt_pkg::result_t    res_r, res_nxt;
  logic                ov_r, ov_nxt;

  logic                we;
  logic [IW-1:0]       waddr, raddr;
  logic [KEY_BITS-1:0] wkey, rkey;
  logic [2:0]          wtype, rtype;
  logic [31:0]         wpay, rpay;
  logic [CW-1:0]       mid;

  skt_store #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .IW(IW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wkey(wkey), .wtype(wtype),
    .wpayload(wpay), .raddr(raddr), .rkey(rkey), .rtype(rtype), .rpayload(rpay)
  );

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_status = res_r.status;
  assign out_found_index = res_r.found_index;
  assign out_found_type = res_r.found_type;
  assign out_found_payload = res_r.found_payload;
  assign out_assigned_key = res_r.assigned_key;
  assign out_replaced_warning = res_r.replaced_warning;

  function automatic logic [7:0] idx8(input logic [CW-1:0] v);
    logic [CW+7:0] w;
    w = {8'd0, v};
    return w[7:0];
  endfunction

  function automatic logic [31:0] key32(input logic [KEY_BITS-1:0] v);
    logic [KEY_BITS+31:0] w;
    w = {32'd0, v};
    return w[31:0];
  endfunction

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    pos_nxt = pos_r;
    mode_nxt = mode_r;
    key_nxt = key_r;
    type_nxt = type_r;
    pay_nxt = pay_r;
    res_nxt = res_r;
    ov_nxt = ov_r;
    we = 1'b0;
    waddr = pos_r[IW-1:0];
    wkey = key_r;
    wtype = type_r;
    wpay = pay_r;
    raddr = mid[IW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_mode;
          key_nxt = KEY_BITS'({{KEY_BITS{1'b0}}, in_key});
          type_nxt = in_entry_type;
          pay_nxt = in_payload;
          lo_nxt = '0;
          hi_nxt = count_r;
          res_nxt = '0;
          if (in_mode == skt_pkg::MODE_SPECIAL) begin
            key_nxt = SPEC_FIRST;
            state_nxt = (count_r == '0) ? S_PROBE : S_LASTRD;
          end else if (in_mode == skt_pkg::MODE_UNUSED) begin
            res_nxt.status = skt_pkg::ST_NOTFOUND;
            state_nxt = S_OUT;
            ov_nxt = 1'b1;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_LASTRD: begin
        raddr = IW'(count_r - 1'b1);
        state_nxt = S_LASTWT;
      end
      S_LASTWT: begin
        if (rkey[KEY_BITS-1]) begin
          if (rkey == KEY_ONES) begin
            res_nxt.status = skt_pkg::ST_FULL;
            ov_nxt = 1'b1;
            state_nxt = S_OUT;
          end else begin
            key_nxt = rkey + 1'b1;
            state_nxt = S_PROBE;
          end
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_r < hi_r) begin
          state_nxt = S_WAIT;
        end else if (mode_r == skt_pkg::MODE_LOOKUP) begin
          res_nxt.status = skt_pkg::ST_NOTFOUND;
          ov_nxt = 1'b1;
          state_nxt = S_OUT;
        end else if (count_r == CAP_C) begin
          res_nxt.status = skt_pkg::ST_FULL;
          ov_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          pos_nxt = count_r;
          state_nxt = S_SRD;
        end
      end
      S_WAIT: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rkey == key_r) begin
          res_nxt.found_index = idx8(mid);
          if (mode_r == skt_pkg::MODE_LOOKUP) begin
            res_nxt.found_type = rtype;
            res_nxt.found_payload = rpay;
          end else begin
            res_nxt.replaced_warning = (rtype != skt_pkg::TYPE_DEFERRED);
            res_nxt.assigned_key = key32(key_r);
            we = 1'b1;
            waddr = mid[IW-1:0];
          end
          ov_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          if (rkey < key_r) lo_nxt = mid + 1'b1;
          else hi_nxt = mid;
          state_nxt = S_PROBE;
        end
      end
      S_SRD: begin
        // sift: read the entry below, or place the new one
        if (pos_r == '0) begin
          state_nxt = S_SCMP;
        end else begin
          raddr = IW'(pos_r - 1'b1);
          state_nxt = S_SWT;
        end
      end
      S_SWT: begin
        // hold the read address so the compare sees the entry below
        raddr = IW'(pos_r - 1'b1);
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (pos_r != '0 && rkey > key_r) begin
          we = 1'b1;
          wkey = rkey;
          wtype = rtype;
          wpay = rpay;
          pos_nxt = pos_r - 1'b1;
          state_nxt = S_SRD;
        end else begin
          we = 1'b1;
          count_nxt = count_r + 1'b1;
          res_nxt.found_index = idx8(pos_r);
          res_nxt.assigned_key = key32(key_r);
          ov_nxt = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          ov_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    pos_r <= pos_nxt;
    mode_r <= mode_nxt;
    key_r <= key_nxt;
    type_r <= type_nxt;
    pay_r <= pay_nxt;
    res_r <= res_nxt;
  end

endmodule

// ===== rtl/skt_store.sv =====
// Entry memory: one write port, one registered read port.
module skt_store #(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32,
  parameter int IW = $clog2(CAPACITY)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IW-1:0]       waddr,
  input  logic [KEY_BITS-1:0] wkey,
  input  logic [2:0]          wtype,
  input  logic [31:0]         wpayload,
  input  logic [IW-1:0]       raddr,
  output logic [KEY_BITS-1:0] rkey,
  output logic [2:0]          rtype,
  output logic [31:0]         rpayload
);

  logic [KEY_BITS+34:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wkey, wtype, wpayload};
    {rkey, rtype, rpayload} <= mem[raddr];
  end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the sorted key table: predicts every result and compares it.
module tb;

  localparam int TABLE_DEPTH = 256;
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [31:0] in_key;
  logic [2:0]  in_entry_type;
  logic [31:0] in_payload;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [7:0]  out_found_index;
  logic [2:0]  out_found_type;
  logic [31:0] out_found_payload;
  logic [31:0] out_assigned_key;
  logic        out_replaced_warning;

  sorted_key_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode), .in_key(in_key),
    .in_entry_type(in_entry_type), .in_payload(in_payload),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_found_index(out_found_index), .out_found_type(out_found_type),
    .out_found_payload(out_found_payload), .out_assigned_key(out_assigned_key),
    .out_replaced_warning(out_replaced_warning)
  );

  // shadow table
  logic [31:0] shadow_keys [TABLE_DEPTH];
  logic [2:0]  shadow_types [TABLE_DEPTH];
  logic [31:0] shadow_payloads [TABLE_DEPTH];
  int          shadow_count;

  skt_pkg::result_t expected_results [$];
  int  error_count;
  int  items_sent;
  int  results_seen;
  int  idle_cycles;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  timed_out;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic bit find_key(input logic [31:0] key, output int pos);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = shadow_count;
    pos = 0;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_keys[mid] == key) begin
        pos = mid;
        return 1'b1;
      end
      if (shadow_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return 1'b0;
  endfunction

  function automatic void store_entry(input logic [31:0] key, input logic [2:0] etype,
                                      input logic [31:0] payload,
                                      inout skt_pkg::result_t res);
    int pos;
    if (find_key(key, pos)) begin
      res.replaced_warning = (shadow_types[pos] != skt_pkg::TYPE_DEFERRED);
      shadow_types[pos] = etype;
      shadow_payloads[pos] = payload;
    end else begin
      if (shadow_count >= TABLE_DEPTH) begin
        res.status = skt_pkg::ST_FULL;
        return;
      end
      pos = shadow_count;
      while (pos > 0 && shadow_keys[pos-1] > key) begin
        shadow_keys[pos] = shadow_keys[pos-1];
        shadow_types[pos] = shadow_types[pos-1];
        shadow_payloads[pos] = shadow_payloads[pos-1];
        pos--;
      end
      shadow_keys[pos] = key;
      shadow_types[pos] = etype;
      shadow_payloads[pos] = payload;
      shadow_count++;
    end
    res.status = skt_pkg::ST_OK;
    res.found_index = pos[7:0];
    res.assigned_key = key;
  endfunction

  function automatic skt_pkg::result_t table_apply(input logic [1:0] mode,
                                                   input logic [31:0] key,
                                                   input logic [2:0] etype,
                                                   input logic [31:0] payload);
    skt_pkg::result_t res;
    int pos;
    logic [31:0] fresh_key;
    res = '0;
    case (mode)
      skt_pkg::MODE_LOOKUP: begin
        if (find_key(key, pos)) begin
          res.status = skt_pkg::ST_OK;
          res.found_index = pos[7:0];
          res.found_type = shadow_types[pos];
          res.found_payload = shadow_payloads[pos];
        end else begin
          res.status = skt_pkg::ST_NOTFOUND;
        end
      end
      skt_pkg::MODE_INSERT: store_entry(key, etype, payload, res);
      skt_pkg::MODE_SPECIAL: begin
        fresh_key = 32'h8000_0000;
        if (shadow_count > 0 && shadow_keys[shadow_count-1][31]) begin
          if (shadow_keys[shadow_count-1] == 32'hFFFF_FFFF) begin
            res.status = skt_pkg::ST_FULL;
            return res;
          end
          fresh_key = shadow_keys[shadow_count-1] + 32'd1;
        end
        store_entry(fresh_key, etype, payload, res);
      end
      default: res.status = skt_pkg::ST_NOTFOUND;
    endcase
    return res;
  endfunction

  // valid stays high after the accepting edge; the next call or the drain drops it
  task automatic send_item(input logic [1:0] mode, input logic [31:0] key,
                           input logic [2:0] etype, input logic [31:0] payload);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_key <= key;
    in_entry_type <= etype;
    in_payload <= payload;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(table_apply(mode, key, etype, payload));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // pick a key near stored ones so lookups hit and inserts overwrite often
  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(9);
    if (shadow_count > 0 && sel < 5)
      return shadow_keys[$urandom_range(shadow_count - 1)];
    if (sel < 7) return $urandom_range(63);
    if (sel == 7) return 32'h8000_0000 + $urandom_range(15);
    return $urandom;
  endfunction

  task automatic test_directed();
    send_item(skt_pkg::MODE_LOOKUP, 32'd0, 3'd0, 32'd0);             // empty table miss
    send_item(skt_pkg::MODE_SPECIAL, 32'd0, 3'd7, 32'hFFFF_FFFF);    // first special key
    send_item(skt_pkg::MODE_SPECIAL, 32'hFFFF_FFFF, 3'd6, 32'd1);
    send_item(skt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 3'd6, 32'hA5A5_5A5A);
    send_item(skt_pkg::MODE_SPECIAL, 32'd0, 3'd1, 32'd2);            // wrap refused
    send_item(skt_pkg::MODE_INSERT, 32'd0, 3'd7, 32'h0000_0000);
    send_item(skt_pkg::MODE_INSERT, 32'h7FFF_FFFF, 3'd3, 32'h1234_5678);
    send_item(skt_pkg::MODE_INSERT, 32'd5, 3'd2, 32'h5555_AAAA);
    send_item(skt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 3'd4, 32'd3);     // overwrite deferred
    send_item(skt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 3'd5, 32'd4);     // overwrite with warning
    send_item(skt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 3'd0, 32'd0);
    send_item(skt_pkg::MODE_LOOKUP, 32'd0, 3'd0, 32'd0);
    send_item(skt_pkg::MODE_LOOKUP, 32'd5, 3'd0, 32'd0);
    send_item(skt_pkg::MODE_LOOKUP, 32'd6, 3'd0, 32'd0);
    send_item(skt_pkg::MODE_UNUSED, 32'd5, 3'd7, 32'hFFFF_FFFF);     // unused mode
    send_item(skt_pkg::MODE_LOOKUP, 32'h8000_0001, 3'd0, 32'd0);
    wait_drained();
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    int sel;
    logic [1:0] mode;
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) mode = skt_pkg::MODE_LOOKUP;
      else if (sel < 85) mode = skt_pkg::MODE_INSERT;
      else if (sel < 97) mode = skt_pkg::MODE_SPECIAL;
      else mode = skt_pkg::MODE_UNUSED;
      send_item(mode, pick_key(), $urandom_range(7), $urandom);
    end
    wait_drained();
  endtask

  // fill to capacity, then probe full behavior and lookups on a full table
  task automatic test_full_table();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (shadow_count < TABLE_DEPTH)
      send_item(skt_pkg::MODE_INSERT, $urandom, $urandom_range(7), $urandom);
    send_item(skt_pkg::MODE_INSERT, 32'h0000_0000 ^ $urandom, 3'd1, 32'd9);
    send_item(skt_pkg::MODE_SPECIAL, 32'd0, 3'd1, 32'd9);
    send_item(skt_pkg::MODE_INSERT, shadow_keys[TABLE_DEPTH-1], 3'd2, 32'hDEAD_BEEF);
    send_item(skt_pkg::MODE_INSERT, shadow_keys[0], 3'd6, 32'hFFFF_FFFF);
    for (int i = 0; i < 40; i++) begin
      send_idle_pct = 29;
      recv_stall_pct = 29;
      send_item(skt_pkg::MODE_LOOKUP, pick_key(), 3'd0, 32'd0);
    end
    wait_drained();
  endtask

  // result check
  always @(posedge clk) begin
    skt_pkg::result_t want;
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d", $time, out_status);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (want != {out_status, out_found_index, out_found_type, out_found_payload,
                       out_assigned_key, out_replaced_warning}) begin
            $display("%0t: mismatch exp st=%0d idx=%0d ty=%0d pl=%h key=%h w=%0b",
                     $time, want.status, want.found_index, want.found_type,
                     want.found_payload, want.assigned_key, want.replaced_warning);
            $display("%0t:          got st=%0d idx=%0d ty=%0d pl=%h key=%h w=%0b",
                     $time, out_status, out_found_index, out_found_type,
                     out_found_payload, out_assigned_key, out_replaced_warning);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results pending", expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0;
    in_key = '0;
    in_entry_type = '0;
    in_payload = '0;
    out_ready = 1'b0;
    error_count = 0;
    items_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shadow_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(160, 0, 0);
    test_random(160, 62, 0);
    test_random(160, 0, 62);
    test_random(160, 29, 29);
    test_full_table();
    test_random(60, 29, 29);
    repeat (50) @(posedge clk);
    $display("Sent %0d items (lookup, insert, special, unused mode), %0d results checked,",
             items_sent, results_seen);
    $display("table filled to %0d entries under four idle/stall mixes.", shadow_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/skt_pkg.sv
rtl/skt_store.sv
rtl/sorted_key_table.sv
verif/tb.sv
